// ----- design/ibcs_pkg.sv -----
`default_nettype none

package ibcs_pkg;

   localparam int AXES        = 6;
   localparam int AXIS_IDX_W  = 3;
   localparam int ACCEL_Z     = 2;

   localparam int RAW_W       = 16;
   localparam int SUM_W       = 26;
   localparam int GRAV_W      = 15;
   localparam logic [GRAV_W-1:0] GRAV_RESET = 15'd16384;
   localparam int CAL_SAMPLES_DEFAULT = 200;

   localparam int ACCEL_W     = 16;
   localparam int RATE_W      = 19;

   // filter value is q8 fixed point
   localparam int FILT_W      = 28;
   localparam int FRAC_BITS   = 8;
   localparam int QMAG_W      = 26;

   // scale n*NUM/DEN is split into n*(NUM/DEN) plus floor(n*rem/DEN) by reciprocal
   localparam longint ACC_NUM = 980665;
   localparam longint ACC_DEN = 6400;
   localparam longint GYR_NUM = 256000;
   localparam longint GYR_DEN = 131;

   localparam int SCALE_INT_W   = 11;
   localparam int SCALE_SHIFT   = 28;
   localparam int SCALE_RECIP_W = 28;

   localparam longint ACC_INT   = ACC_NUM / ACC_DEN;
   localparam longint ACC_REM   = ACC_NUM % ACC_DEN;
   localparam longint ACC_RECIP = (ACC_REM * (longint'(1) << SCALE_SHIFT) + ACC_DEN - 1) / ACC_DEN;
   localparam longint GYR_INT   = GYR_NUM / GYR_DEN;
   localparam longint GYR_REM   = GYR_NUM % GYR_DEN;
   localparam longint GYR_RECIP = (GYR_REM * (longint'(1) << SCALE_SHIFT) + GYR_DEN - 1) / GYR_DEN;

   typedef enum logic {
      AXIS_ACCEL = 1'b0,
      AXIS_GYRO  = 1'b1
   } axis_kind_type;

   typedef struct packed {
      logic s1_load;
      logic s2_load;
      logic s3_load;
      logic out_load;
      logic seeded;
   } lane_ctl_type;

   function automatic int out_width(axis_kind_type kind);
      return (kind == AXIS_GYRO) ? RATE_W : ACCEL_W;
   endfunction

endpackage

`default_nettype wire

// ----- design/imu_bias_calibrate_and_smooth_top.sv -----
`default_nettype none

// Six-axis bias calibration and smoothing. After reset the first CAL_SAMPLES requests
// are summed per axis (one per cycle, no response), with csr gravity counts taken off Z.
// The request channel then stalls while one shared three-stage reciprocal multiplier
// turns each of the six sums into an offset, one axis per cycle. From then on every
// request gives one response: offset removal, scaling to mm/s^2 or millidegrees/s and
// the halving filter run in a four-register pipeline (s1, s2, s3, out), so a request
// can be taken every cycle unless rsp_stall backs the pipeline up.
// gravity counts should be written before calibration ends; later writes do nothing.
module imu_bias_calibrate_and_smooth_top #(
   parameter int CAL_SAMPLES = ibcs_pkg::CAL_SAMPLES_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   csr_write_enable,
   input  logic [ibcs_pkg::GRAV_W-1:0]            csr_write_data,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [ibcs_pkg::RAW_W-1:0]      req_accel_x_raw,
   input  logic signed [ibcs_pkg::RAW_W-1:0]      req_accel_y_raw,
   input  logic signed [ibcs_pkg::RAW_W-1:0]      req_accel_z_raw,
   input  logic signed [ibcs_pkg::RAW_W-1:0]      req_gyro_x_raw,
   input  logic signed [ibcs_pkg::RAW_W-1:0]      req_gyro_y_raw,
   input  logic signed [ibcs_pkg::RAW_W-1:0]      req_gyro_z_raw,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [ibcs_pkg::ACCEL_W-1:0]    rsp_accel_x_mms2,
   output logic signed [ibcs_pkg::ACCEL_W-1:0]    rsp_accel_y_mms2,
   output logic signed [ibcs_pkg::ACCEL_W-1:0]    rsp_accel_z_mms2,
   output logic signed [ibcs_pkg::RATE_W-1:0]     rsp_rate_x_mdps,
   output logic signed [ibcs_pkg::RATE_W-1:0]     rsp_rate_y_mdps,
   output logic signed [ibcs_pkg::RATE_W-1:0]     rsp_rate_z_mdps
);

   localparam int AXES   = ibcs_pkg::AXES;
   localparam int IDX_W  = ibcs_pkg::AXIS_IDX_W;
   localparam int RAW_W  = ibcs_pkg::RAW_W;
   localparam int SUM_W  = ibcs_pkg::SUM_W;
   localparam int GRAV_W = ibcs_pkg::GRAV_W;
   localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);
   localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(CAL_SAMPLES - 1);
   localparam logic [IDX_W-1:0] AXIS_LAST = IDX_W'(AXES - 1);

   typedef enum logic [4:0] {
      PH_CAL    = 5'b00001,
      PH_SETTLE = 5'b00010,
      PH_DIV    = 5'b00100,
      PH_DRAIN  = 5'b01000,
      PH_RUN    = 5'b10000
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [GRAV_W-1:0]       gravity_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    cal_valid_ff;
   logic [RAW_W-1:0]        cal_raw_ff [AXES];
   logic [SUM_W-1:0]        sum_ff [AXES];
   logic [SUM_W-1:0]        sum_in [AXES];
   logic [RAW_W-1:0]        offset_ff [AXES];
   logic [IDX_W-1:0]        div_idx_ff;
   logic                    seeded_ff;
   logic                    s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;

   logic [RAW_W-1:0]        req_raw [AXES];
   logic                    req_accept, cal_accept, run_accept;
   logic                    s1_free, s2_free, s3_free;
   logic                    s2_load, s3_load, out_load;
   logic                    div_out_valid;
   logic [IDX_W-1:0]        div_out_idx;
   logic [RAW_W-1:0]        div_quot;
   ibcs_pkg::lane_ctl_type  lane_ctl;

   assign req_raw[0] = req_accel_x_raw;
   assign req_raw[1] = req_accel_y_raw;
   assign req_raw[2] = req_accel_z_raw;
   assign req_raw[3] = req_gyro_x_raw;
   assign req_raw[4] = req_gyro_y_raw;
   assign req_raw[5] = req_gyro_z_raw;

   // pipeline advance, back to front
   always_comb begin
      out_load = s3_valid_ff && (!out_valid_ff || !rsp_stall);
      s3_free  = !s3_valid_ff || out_load;
      s3_load  = s2_valid_ff && s3_free;
      s2_free  = !s2_valid_ff || s3_load;
      s2_load  = s1_valid_ff && s2_free;
      s1_free  = !s1_valid_ff || s2_load;
   end

   always_comb begin
      case (phase_ff)
         PH_CAL:  req_stall = 1'b0;
         PH_RUN:  req_stall = !s1_free;
         default: req_stall = 1'b1;
      endcase
      req_accept = req_valid && !req_stall;
      cal_accept = req_accept && (phase_ff == PH_CAL);
      run_accept = req_accept && (phase_ff == PH_RUN);
   end

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_CAL: begin
            if (cal_accept && (cnt_ff == CNT_LAST)) begin
               phase_in = PH_SETTLE;
            end
         end
         // last calibration request lands in the sums here
         PH_SETTLE: phase_in = PH_DIV;
         PH_DIV: begin
            if (div_idx_ff == AXIS_LAST) begin
               phase_in = PH_DRAIN;
            end
         end
         PH_DRAIN: begin
            if (div_out_valid && (div_out_idx == AXIS_LAST)) begin
               phase_in = PH_RUN;
            end
         end
         PH_RUN:  phase_in = PH_RUN;
         default: phase_in = PH_CAL;
      endcase
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         sum_in[i] = sum_ff[i] + {{(SUM_W-RAW_W){cal_raw_ff[i][RAW_W-1]}}, cal_raw_ff[i]};
         if (i == ibcs_pkg::ACCEL_Z) begin
            sum_in[i] = sum_in[i] - SUM_W'(gravity_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CAL;
         gravity_ff   <= ibcs_pkg::GRAV_RESET;
         cnt_ff       <= '0;
         cal_valid_ff <= 1'b0;
         div_idx_ff   <= '0;
         seeded_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         phase_ff     <= phase_in;
         cal_valid_ff <= cal_accept;
         if (csr_write_enable) begin
            gravity_ff <= csr_write_data;
         end
         if (cal_accept) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (cal_valid_ff) begin
            for (int i = 0; i < AXES; i++) begin
               sum_ff[i] <= sum_in[i];
            end
         end
         if (phase_ff == PH_SETTLE) begin
            div_idx_ff <= '0;
         end else if ((phase_ff == PH_DIV) && (div_idx_ff != AXIS_LAST)) begin
            div_idx_ff <= div_idx_ff + IDX_W'(1);
         end
         if (out_load) begin
            seeded_ff <= 1'b1;
         end
         s1_valid_ff <= run_accept || (s1_valid_ff && !s2_load);
         s2_valid_ff <= s2_load || (s2_valid_ff && !s3_load);
         s3_valid_ff <= s3_load || (s3_valid_ff && !out_load);
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cal_accept) begin
         for (int i = 0; i < AXES; i++) begin
            cal_raw_ff[i] <= req_raw[i];
         end
      end
      if (div_out_valid) begin
         offset_ff[div_out_idx] <= div_quot;
      end
   end

   ibcs_offset_div #(
      .DIVISOR (CAL_SAMPLES)
   ) u_offset_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (phase_ff == PH_DIV),
      .in_idx    (div_idx_ff),
      .in_sum    (sum_ff[div_idx_ff]),
      .out_valid (div_out_valid),
      .out_idx   (div_out_idx),
      .out_quot  (div_quot)
   );

   always_comb begin
      lane_ctl.s1_load  = run_accept;
      lane_ctl.s2_load  = s2_load;
      lane_ctl.s3_load  = s3_load;
      lane_ctl.out_load = out_load;
      lane_ctl.seeded   = seeded_ff;
   end

   ibcs_axis_lane #(.KIND(ibcs_pkg::AXIS_ACCEL)) u_lane_ax (
      .clock (clock), .ctl (lane_ctl), .raw (req_raw[0]), .offset (offset_ff[0]),
      .result (rsp_accel_x_mms2)
   );

   ibcs_axis_lane #(.KIND(ibcs_pkg::AXIS_ACCEL)) u_lane_ay (
      .clock (clock), .ctl (lane_ctl), .raw (req_raw[1]), .offset (offset_ff[1]),
      .result (rsp_accel_y_mms2)
   );

   ibcs_axis_lane #(.KIND(ibcs_pkg::AXIS_ACCEL)) u_lane_az (
      .clock (clock), .ctl (lane_ctl), .raw (req_raw[2]), .offset (offset_ff[2]),
      .result (rsp_accel_z_mms2)
   );

   ibcs_axis_lane #(.KIND(ibcs_pkg::AXIS_GYRO)) u_lane_gx (
      .clock (clock), .ctl (lane_ctl), .raw (req_raw[3]), .offset (offset_ff[3]),
      .result (rsp_rate_x_mdps)
   );

   ibcs_axis_lane #(.KIND(ibcs_pkg::AXIS_GYRO)) u_lane_gy (
      .clock (clock), .ctl (lane_ctl), .raw (req_raw[4]), .offset (offset_ff[4]),
      .result (rsp_rate_y_mdps)
   );

   ibcs_axis_lane #(.KIND(ibcs_pkg::AXIS_GYRO)) u_lane_gz (
      .clock (clock), .ctl (lane_ctl), .raw (req_raw[5]), .offset (offset_ff[5]),
      .result (rsp_rate_z_mdps)
   );

   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

// ----- design/ibcs_offset_div.sv -----
`default_nettype none

module ibcs_offset_div #(
   parameter int DIVISOR = ibcs_pkg::CAL_SAMPLES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [ibcs_pkg::AXIS_IDX_W-1:0]   in_idx,
   input  logic [ibcs_pkg::SUM_W-1:0]        in_sum,
   output logic                              out_valid,
   output logic [ibcs_pkg::AXIS_IDX_W-1:0]   out_idx,
   output logic [ibcs_pkg::RAW_W-1:0]        out_quot
);

   localparam int SUM_W   = ibcs_pkg::SUM_W;
   localparam int IDX_W   = ibcs_pkg::AXIS_IDX_W;
   // exact floor(n/DIVISOR) for every sum magnitude with a rounded-up reciprocal
   localparam int SHIFT   = SUM_W - 1 + $clog2(DIVISOR + 1);
   localparam int RECIP_W = SHIFT + 1;
   localparam int LO_W    = RECIP_W / 2;
   localparam int HI_W    = RECIP_W - LO_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((longint'(1) << SHIFT) + longint'(DIVISOR) - 1) / longint'(DIVISOR));
   localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
   localparam logic [HI_W-1:0] RECIP_HI = RECIP[RECIP_W-1:LO_W];

   logic                    v1_ff, v2_ff, v3_ff;
   logic [IDX_W-1:0]        idx1_ff, idx2_ff, idx3_ff;
   logic                    neg1_ff, neg2_ff, neg3_ff;
   logic [SUM_W-1:0]        mag1_ff, mag2_ff;
   logic [SUM_W+LO_W-1:0]   plo2_ff, plo3_ff;
   logic [SUM_W+HI_W-1:0]   phi3_ff;

   logic [SUM_W-1:0]        mag1_in;
   logic [SUM_W+LO_W-1:0]   plo2_in;
   logic [SUM_W+HI_W-1:0]   phi3_in;
   logic [SUM_W+RECIP_W-1:0] full;
   logic [SUM_W-1:0]        quot;
   logic [SUM_W-1:0]        quot_signed;

   always_comb begin
      mag1_in     = in_sum[SUM_W-1] ? (SUM_W'(0) - in_sum) : in_sum;
      plo2_in     = mag1_ff * RECIP_LO;
      phi3_in     = mag2_ff * RECIP_HI;
      full        = {phi3_ff, LO_W'(0)} + (SUM_W+RECIP_W)'(plo3_ff);
      quot        = full[SHIFT +: SUM_W];
      quot_signed = neg3_ff ? (SUM_W'(0) - quot) : quot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff <= in_idx;
      neg1_ff <= in_sum[SUM_W-1];
      mag1_ff <= mag1_in;
      idx2_ff <= idx1_ff;
      neg2_ff <= neg1_ff;
      mag2_ff <= mag1_ff;
      plo2_ff <= plo2_in;
      idx3_ff <= idx2_ff;
      neg3_ff <= neg2_ff;
      plo3_ff <= plo2_ff;
      phi3_ff <= phi3_in;
   end

   assign out_valid = v3_ff;
   assign out_idx   = idx3_ff;
   assign out_quot  = quot_signed[ibcs_pkg::RAW_W-1:0];

endmodule

`default_nettype wire

// ----- design/ibcs_axis_lane.sv -----
`default_nettype none

module ibcs_axis_lane #(
   parameter ibcs_pkg::axis_kind_type KIND = ibcs_pkg::AXIS_ACCEL
) (
   input  logic                                 clock,
   input  ibcs_pkg::lane_ctl_type               ctl,
   input  logic [ibcs_pkg::RAW_W-1:0]           raw,
   input  logic [ibcs_pkg::RAW_W-1:0]           offset,
   output logic [ibcs_pkg::out_width(KIND)-1:0] result
);

   localparam int RAW_W   = ibcs_pkg::RAW_W;
   localparam int QMAG_W  = ibcs_pkg::QMAG_W;
   localparam int FILT_W  = ibcs_pkg::FILT_W;
   localparam int FRAC_W  = ibcs_pkg::FRAC_BITS;
   localparam int INT_W   = ibcs_pkg::SCALE_INT_W;
   localparam int RCP_W   = ibcs_pkg::SCALE_RECIP_W;
   localparam int OUT_W   = ibcs_pkg::out_width(KIND);
   localparam logic [INT_W-1:0] SCALE_INT = (KIND == ibcs_pkg::AXIS_GYRO) ?
      INT_W'(ibcs_pkg::GYR_INT) : INT_W'(ibcs_pkg::ACC_INT);
   localparam logic [RCP_W-1:0] SCALE_RECIP = (KIND == ibcs_pkg::AXIS_GYRO) ?
      RCP_W'(ibcs_pkg::GYR_RECIP) : RCP_W'(ibcs_pkg::ACC_RECIP);

   logic [RAW_W-1:0]        raw_ff;
   logic [QMAG_W-1:0]       int_ff;
   logic [RAW_W-1:0]        frac_ff;
   logic                    neg_ff;
   logic [FILT_W-1:0]       q_ff;
   logic [FILT_W-1:0]       filt_ff;
   logic [OUT_W-1:0]        result_ff;

   logic [RAW_W-1:0]        diff;
   logic                    neg_in;
   logic [RAW_W-1:0]        mag;
   logic [RAW_W+INT_W-1:0]  int_prod;
   logic [RAW_W+RCP_W-1:0]  frac_prod;
   logic [QMAG_W-1:0]       qmag;
   logic [FILT_W-1:0]       qext;
   logic [FILT_W-1:0]       q_in;
   logic [FILT_W-1:0]       base;
   logic [FILT_W:0]         pair;
   logic [FILT_W:0]         rounded;
   logic [FILT_W-1:0]       filt_in;
   logic [FILT_W:0]         biased;
   logic [OUT_W-1:0]        result_in;

   always_comb begin
      diff      = raw_ff - offset;
      neg_in    = diff[RAW_W-1];
      mag       = neg_in ? (RAW_W'(0) - diff) : diff;
      int_prod  = mag * SCALE_INT;
      frac_prod = mag * SCALE_RECIP;

      qmag = int_ff + QMAG_W'(frac_ff);
      qext = FILT_W'(qmag);
      q_in = neg_ff ? (FILT_W'(0) - qext) : qext;

      // first run request loads the filter with its own value
      base    = ctl.seeded ? filt_ff : q_ff;
      pair    = {base[FILT_W-1], base} + {q_ff[FILT_W-1], q_ff};
      // halve toward zero
      rounded = pair + (FILT_W+1)'(pair[FILT_W]);
      filt_in = rounded[FILT_W:1];
      // drop fraction toward zero
      biased  = {filt_in[FILT_W-1], filt_in} +
                (filt_in[FILT_W-1] ? (FILT_W+1)'({FRAC_W{1'b1}}) : (FILT_W+1)'(0));
      result_in = biased[FRAC_W +: OUT_W];
   end

   always_ff @(posedge clock) begin
      if (ctl.s1_load) begin
         raw_ff <= raw;
      end
      if (ctl.s2_load) begin
         int_ff  <= int_prod[QMAG_W-1:0];
         frac_ff <= frac_prod[ibcs_pkg::SCALE_SHIFT +: RAW_W];
         neg_ff  <= neg_in;
      end
      if (ctl.s3_load) begin
         q_ff <= q_in;
      end
      if (ctl.out_load) begin
         filt_ff   <= filt_in;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire
